// ===== hdl/bbe_pkg.sv =====
// package for the binary boundary extractor
// shared constants, register codes and the command record between front and back
`default_nettype none

package bbe_pkg;

  // frame limits and field widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4095;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // reset values of the registers
  localparam logic [CFG_W-1:0] RST_WIDTH     = 12'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT    = 12'd480;
  localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd128;
  localparam logic [CFG_W-1:0] MIN_SIDE      = 12'd3;

  // window layout: bit 8 newest pixel, bit 4 center
  localparam logic [8:0] WIN_KEEP   = 9'h0DB;
  localparam logic [8:0] WIN_CENTER = 9'h010;
  localparam logic [8:0] WIN_ALL    = 9'h1FF;

  // result slots a command can expand into, in emission order
  localparam int EMIT_N    = 4;
  localparam int EMIT_MAIN = 0;  // (r-1, c-1) with the window decision
  localparam int EMIT_REND = 1;  // (r-1, c) right border of the row above
  localparam int EMIT_LSTA = 2;  // (r, c-1) on the bottom row
  localparam int EMIT_LSTB = 3;  // (r, c) bottom-right corner, last of frame

  // command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              white;
    logic [EMIT_N-1:0] emit;
  } bbe_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/binary_boundary_extract_3x3.sv =====
// Binary boundary extractor, 3x3 neighborhood. Pixels enter in raster order, one per
// cycle unless stalled, and go through one register stage that reads a 2048 x 2-bit line
// store (one read and one write port) and shifts the 3x3 window; each pixel that completes
// a neighborhood leaves a command in a 4-entry queue. The back end turns each command into
// one to four results and sends them one per cycle, unless stalled, through an output
// register. The top row gives no results, inner rows give width results for width pixels
// (two at the row end, none at the row start) and the bottom row two per pixel, so the
// output port, at one result per cycle, sets the sustained rate: one pixel per cycle
// on all but the bottom row, where the queue fills and stalls the input to one pixel per
// two results. A pixel's first result passes stage A, the queue and the output register.
// Writing width or height restarts the frame; the line store needs no clearing pass.
// top level; uses bbe_pkg, bbe_front, bbe_queue and bbe_back
`default_nettype none

module binary_boundary_extract_3x3 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bbe_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bbe_pkg::PIX_W-1:0]     red_i,
  input  wire logic [bbe_pkg::PIX_W-1:0]     green_i,
  input  wire logic [bbe_pkg::PIX_W-1:0]     blue_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bbe_pkg::ROW_W-1:0]          out_row_o,
  output logic [bbe_pkg::COL_W-1:0]          out_col_o,
  output logic                               is_white_o,
  output logic                               frame_last_o
);

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  bbe_pkg::bbe_cmd_t cmd;
  bbe_pkg::bbe_cmd_t head;

  // register writes always complete
  assign cfg_ready_o = 1'b1;

  bbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  bbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (head),
    .empty_o (empty)
  );

  bbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .is_white_o   (is_white_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/bbe_front.sv =====
// front end: configuration registers, pixel intake, binarizing, line store and window
// uses bbe_pkg; produces one command record per pixel that causes results
`default_nettype none

module bbe_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bbe_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bbe_pkg::PIX_W-1:0]     red_i,
  input  wire logic [bbe_pkg::PIX_W-1:0]     green_i,
  input  wire logic [bbe_pkg::PIX_W-1:0]     blue_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output bbe_pkg::bbe_cmd_t                  cmd_o
);

  logic [bbe_pkg::CFG_W-1:0] width_q, width_d;
  logic [bbe_pkg::CFG_W-1:0] height_q, height_d;
  logic [bbe_pkg::PIX_W-1:0] thr_q, thr_d;
  logic [bbe_pkg::ROW_W-1:0] row_q, row_d;
  logic [bbe_pkg::COL_W-1:0] col_q, col_d;
  logic                      a_valid_q, a_valid_d;
  logic                      a_bit_q;
  logic [bbe_pkg::ROW_W-1:0] a_row_q;
  logic [bbe_pkg::COL_W-1:0] a_col_q;
  logic [8:0]                win_q, win_d;
  logic [1:0]                rd_q;
  logic [1:0]                line_mem [bbe_pkg::MAX_WIDTH];

  logic                      accept;
  logic                      go;
  logic [bbe_pkg::SUM_W-1:0] gray_sum;
  logic                      pix_bit;
  logic                      col_last;
  logic                      row_last;
  logic                      a_col_last;
  logic                      a_row_last;
  logic                      a_row_nz;
  logic                      a_col_nz;
  logic                      interior;
  logic                      white;
  logic [bbe_pkg::EMIT_N-1:0] emit;

  // handshake: stage A drains into the queue whenever it has room
  assign go         = a_valid_q && !full_i;
  assign in_stall_o = a_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // gray level and threshold
  assign gray_sum = bbe_pkg::SUM_W'(red_i) * 13'd11 + bbe_pkg::SUM_W'(green_i) * 13'd16
                  + bbe_pkg::SUM_W'(blue_i) * 13'd5;
  assign pix_bit  = gray_sum[bbe_pkg::SUM_W-1:5] > thr_q;

  // raster position of the incoming pixel
  assign col_last = ({1'b0, col_q} == width_q - 12'd1);
  assign row_last = (row_q == height_q - 12'd1);

  // configuration writes, clamped to the supported frame sizes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thr_d    = thr_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbe_pkg::REG_WIDTH: begin
          if (cfg_data_i < bbe_pkg::MIN_SIDE) begin
            width_d = bbe_pkg::MIN_SIDE;
          end else if (cfg_data_i > bbe_pkg::CFG_W'(bbe_pkg::MAX_WIDTH)) begin
            width_d = bbe_pkg::CFG_W'(bbe_pkg::MAX_WIDTH);
          end else begin
            width_d = cfg_data_i;
          end
        end
        bbe_pkg::REG_HEIGHT: begin
          if (cfg_data_i < bbe_pkg::MIN_SIDE) begin
            height_d = bbe_pkg::MIN_SIDE;
          end else if (cfg_data_i > bbe_pkg::CFG_W'(bbe_pkg::MAX_HEIGHT)) begin
            height_d = bbe_pkg::CFG_W'(bbe_pkg::MAX_HEIGHT);
          end else begin
            height_d = cfg_data_i;
          end
        end
        bbe_pkg::REG_THRESHOLD: begin
          thr_d = cfg_data_i[bbe_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // row and column counters, restarted by a size write
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_valid_i && (cfg_index_i == bbe_pkg::REG_WIDTH ||
                        cfg_index_i == bbe_pkg::REG_HEIGHT)) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 11'd1;
      end
    end
  end

  // stage A occupancy
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (go) begin
      a_valid_d = 1'b0;
    end
  end

  // window shift with the two stored rows and the new bit
  assign win_d = ((win_q >> 1) & bbe_pkg::WIN_KEEP)
               | {a_bit_q, 2'b00, rd_q[1], 2'b00, rd_q[0], 2'b00};

  // decision for the pixel one row up and one column left
  assign a_col_last = ({1'b0, a_col_q} == width_q - 12'd1);
  assign a_row_last = (a_row_q == height_q - 12'd1);
  assign a_row_nz   = (a_row_q != '0);
  assign a_col_nz   = (a_col_q != '0);
  assign interior   = (a_row_q >= 12'd2) && (a_col_q >= 11'd2);
  assign white      = !(interior && !win_d[4] && ((win_d & ~bbe_pkg::WIN_CENTER) != '0));

  always_comb begin
    emit = '0;
    emit[bbe_pkg::EMIT_MAIN] = a_row_nz && a_col_nz;
    emit[bbe_pkg::EMIT_REND] = a_row_nz && a_col_last;
    emit[bbe_pkg::EMIT_LSTA] = a_row_last && a_col_nz;
    emit[bbe_pkg::EMIT_LSTB] = a_row_last && a_col_last;
  end

  assign push_o      = go && (emit != '0);
  assign cmd_o.row   = a_row_q;
  assign cmd_o.col   = a_col_q;
  assign cmd_o.white = white;
  assign cmd_o.emit  = emit;

  // line store: bit 1 previous row, bit 0 the row before it
  always_ff @(posedge clk_i) begin
    if (go) begin
      line_mem[a_col_q] <= {a_bit_q, rd_q[1]};
    end
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
  end

  // stage A payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_bit_q <= pix_bit;
      a_row_q <= row_q;
      a_col_q <= col_q;
    end
  end

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bbe_pkg::RST_WIDTH;
      height_q  <= bbe_pkg::RST_HEIGHT;
      thr_q     <= bbe_pkg::RST_THRESHOLD;
      row_q     <= '0;
      col_q     <= '0;
      a_valid_q <= 1'b0;
      win_q     <= bbe_pkg::WIN_ALL;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      thr_q     <= thr_d;
      row_q     <= row_d;
      col_q     <= col_d;
      a_valid_q <= a_valid_d;
      if (go) begin
        win_q <= win_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bbe_queue.sv =====
// small command queue between front and back
// uses bbe_pkg for the record type and depth
`default_nettype none

module bbe_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bbe_pkg::bbe_cmd_t din_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output bbe_pkg::bbe_cmd_t      dout_o,
  output logic                   empty_o
);

  bbe_pkg::bbe_cmd_t         slots [bbe_pkg::QDEPTH];
  logic [bbe_pkg::QPTR_W-1:0] wr_q, wr_d;
  logic [bbe_pkg::QPTR_W-1:0] rd_q, rd_d;
  logic [bbe_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (cnt_q == (bbe_pkg::QPTR_W+1)'(bbe_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = slots[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bbe_back.sv =====
// back end: expands commands into results, one per unstalled cycle, via the output register
// uses bbe_pkg for the record type and slot positions
`default_nettype none

module bbe_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bbe_pkg::bbe_cmd_t         head_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [bbe_pkg::ROW_W-1:0]      out_row_o,
  output logic [bbe_pkg::COL_W-1:0]      out_col_o,
  output logic                           is_white_o,
  output logic                           frame_last_o
);

  logic [bbe_pkg::EMIT_N-1:0] sent_q, sent_d;
  logic [bbe_pkg::EMIT_N-1:0] pend;
  logic [bbe_pkg::EMIT_N-1:0] sel;
  logic                       load;
  logic                       valid_q, valid_d;
  logic [bbe_pkg::ROW_W-1:0]  row_d, row_q;
  logic [bbe_pkg::COL_W-1:0]  col_d, col_q;
  logic                       white_d, white_q;
  logic                       last_d, last_q;
  logic [bbe_pkg::ROW_W-1:0]  row_up;
  logic [bbe_pkg::COL_W-1:0]  col_left;

  assign pend = head_i.emit & ~sent_q;
  assign load = !empty_i && (!valid_q || !out_stall_i);

  // next slot in emission order
  always_comb begin
    sel = '0;
    priority if (pend[bbe_pkg::EMIT_MAIN]) begin
      sel[bbe_pkg::EMIT_MAIN] = 1'b1;
    end else if (pend[bbe_pkg::EMIT_REND]) begin
      sel[bbe_pkg::EMIT_REND] = 1'b1;
    end else if (pend[bbe_pkg::EMIT_LSTA]) begin
      sel[bbe_pkg::EMIT_LSTA] = 1'b1;
    end else begin
      sel[bbe_pkg::EMIT_LSTB] = 1'b1;
    end
  end

  // result fields of the chosen slot
  assign row_up   = head_i.row - 12'd1;
  assign col_left = head_i.col - 11'd1;

  always_comb begin
    row_d   = head_i.row;
    col_d   = head_i.col;
    white_d = 1'b1;
    last_d  = 1'b0;
    if (sel[bbe_pkg::EMIT_MAIN]) begin
      row_d   = row_up;
      col_d   = col_left;
      white_d = head_i.white;
    end else if (sel[bbe_pkg::EMIT_REND]) begin
      row_d = row_up;
    end else if (sel[bbe_pkg::EMIT_LSTA]) begin
      col_d = col_left;
    end else begin
      last_d = 1'b1;
    end
  end

  // retire the head once its last pending slot goes out
  assign pop_o = load && ((pend & ~sel) == '0);

  always_comb begin
    sent_d = sent_q;
    if (pop_o) begin
      sent_d = '0;
    end else if (load) begin
      sent_d = sent_q | sel;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q   <= row_d;
      col_q   <= col_d;
      white_q <= white_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      sent_q  <= sent_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign is_white_o   = white_q;
  assign frame_last_o = last_q;

  // the frame's final result is always a border pixel
  a_last_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> is_white_o)
    else $error("frame_last result is not white");

  // the front never queues a command without results
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> head_i.emit != '0)
    else $error("queued command has no result slots");

  // progress marks only ever cover slots of the current head
  a_sent_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (sent_q & ~head_i.emit) == '0)
    else $error("progress mark outside head command");

  // a retired head leaves no progress behind
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> sent_q == '0)
    else $error("progress mark survived a pop");

endmodule

`default_nettype wire
